/* design/timed_event_scheduler_unit_assert.svh */
// Assertion macros for the timed event scheduler
`ifndef TIMED_EVENT_SCHEDULER_UNIT_ASSERT_SVH
`define TIMED_EVENT_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, reset excluded
`define TESU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset excluded
`define TESU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/tesu_pkg.sv */
// Types and codes of the timed event scheduler
`default_nettype none
package tesu_pkg;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_DEL    = 2'd1;
	localparam logic [1:0] CMD_ADV    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_HNDL  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	localparam logic [62:0] IDLE_TIME = {31'h7FFFFFFF, 32'h0};

	typedef struct packed {
		logic [62:0] due;
		logic [3:0]  handler;
		logic [63:0] payload;
		logic [31:0] ident;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] new_id;
		logic [5:0]  run_len;
		logic [4:0]  bus_run_len;
		logic [2:0]  io_run_len;
		logic        fired;
		logic [3:0]  fired_handler;
		logic [63:0] fired_payload;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

/* design/timed_event_scheduler_unit.sv */
// Timed event scheduler: event table in RAM, count keeping and command sequencer
//
// A request is taken when start is high and busy is low; busy stays high until the
// last result of that request has been shown. Results appear on the result ports for
// one cycle each, marked by done, and cannot be held off; last marks the final result
// of a request. Add, an unused command and an advance on an empty table give their result
// from the execute state. Delete and advance walk the event table through the RAM read
// port, one stored event per cycle, the stored events numbering at most SLOTS; an advance
// that stops short of the earliest due time ends after its count update without a scan.
// The user must write the handler_count register through cfg_we/cfg_wdata only while
// the block is idle; the block itself does not enforce this.
`default_nettype none
module timed_event_scheduler_unit #(
	parameter int SLOTS    = 32,
	parameter int MAX_RUN  = 32,
	parameter int HANDLERS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic [1:0]  cmd,
	input  wire logic [3:0]  handler,
	input  wire logic [62:0] delay,
	input  wire logic [63:0] payload,
	input  wire logic [31:0] target_id,
	output logic             done,
	output logic [2:0]       status,
	output logic [31:0]      new_id,
	output logic [5:0]       run_len,
	output logic [4:0]       bus_run_len,
	output logic [2:0]       io_run_len,
	output logic             fired,
	output logic [3:0]       fired_handler,
	output logic [63:0]      fired_payload,
	output logic             last
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int RUN_W = $clog2(MAX_RUN + 1);
	localparam int ENT_W = $bits(tesu_pkg::entry_t);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_ADV2 = 3'd2;
	localparam logic [2:0] S_ADV3 = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;

	logic [2:0]  state_q;
	logic [4:0]  hcount_q;
	logic [1:0]  cmd_q;
	logic [3:0]  handler_q;
	logic [62:0] delay_q;
	logic [63:0] payload_q;
	logic [31:0] target_q;

	logic [CNT_W-1:0] n_q, rd_q, wr_q, idx_s1;
	logic             vld_s1, hit_q, fire_mode_q;
	logic [62:0] main_count_q, bus_count_q, io_count_q, earliest_q, fresh_q;
	logic        bus_rem_q;
	logic [2:0]  io_rem_q;
	logic [31:0] next_ident_q;
	logic [RUN_W-1:0] run_q, brun_q, irun_q;
	logic        pend_vld_q;
	logic [3:0]  pend_handler_q;
	logic [63:0] pend_payload_q;
	logic        done_q;
	tesu_pkg::result_t res_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	tesu_pkg::entry_t ram_wdata, rentry;
	logic [ENT_W-1:0] ram_rdata;

	logic        bad_hndl, full, add_ok, drop, issue, scan_end;
	logic [63:0] due_sum, diff;
	logic [62:0] add_due;
	logic [RUN_W-1:0] run_d, half, eighth;
	logic [RUN_W+2:0] run_x;
	logic        bcar;
	logic [3:0]  io_sum;
	logic [RUN_W+5:0] run_ext, brun_ext, irun_ext;

	function automatic tesu_pkg::result_t make_res(input logic [2:0] st,
			input logic [31:0] id, input logic adv, input logic fi,
			input logic [3:0] fh, input logic [63:0] fp, input logic lst);
		tesu_pkg::result_t r;
		r = '0;
		r.status = st;
		r.new_id = id;
		if (adv) begin
			r.run_len     = run_ext[5:0];
			r.bus_run_len = brun_ext[4:0];
			r.io_run_len  = irun_ext[2:0];
		end
		r.fired         = fi;
		r.fired_handler = fh;
		r.fired_payload = fp;
		r.last          = lst;
		return r;
	endfunction

	tesu_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		rentry   = tesu_pkg::entry_t'(ram_rdata);
		bad_hndl = ({1'b0, handler_q} >= hcount_q) || (32'(handler_q) >= HANDLERS);
		full     = (n_q >= CNT_W'(SLOTS));
		add_ok   = (state_q == S_EXEC) && (cmd_q == tesu_pkg::CMD_ADD) && !bad_hndl && !full;
		due_sum  = {1'b0, main_count_q} + {1'b0, delay_q};
		add_due  = due_sum[63] ? '1 : due_sum[62:0];
		drop     = fire_mode_q ? (rentry.due <= earliest_q)
		                       : (!hit_q && (rentry.ident == target_q));
		issue    = (state_q == S_SCAN) && (rd_q < n_q);
		scan_end = (state_q == S_SCAN) && !issue && !vld_s1;

		ram_we    = 1'b0;
		ram_waddr = n_q[IDX_W-1:0];
		ram_wdata = '{due: add_due, handler: handler_q, payload: payload_q,
		              ident: next_ident_q};
		if (add_ok) begin
			ram_we = 1'b1;
		end else if ((state_q == S_SCAN) && vld_s1 && !drop && (wr_q != idx_s1)) begin
			ram_we    = 1'b1;
			ram_waddr = wr_q[IDX_W-1:0];
			ram_wdata = rentry;
		end

		diff = {1'b0, earliest_q} - {1'b0, main_count_q};
		if (diff[63]) begin
			run_d = '0;
		end else if (diff >= 64'(MAX_RUN)) begin
			run_d = RUN_W'(MAX_RUN);
		end else begin
			run_d = RUN_W'(diff);
		end

		run_x  = {3'b0, run_q};
		half   = run_q >> 1;
		bcar   = bus_rem_q & run_q[0];
		eighth = RUN_W'(run_x >> 3);
		io_sum = {1'b0, io_rem_q} + {1'b0, run_x[2:0]};

		run_ext  = {6'b0, run_q};
		brun_ext = {6'b0, brun_q};
		irun_ext = {6'b0, irun_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			hcount_q     <= 5'd1;
			n_q          <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			vld_s1       <= 1'b0;
			hit_q        <= 1'b0;
			fire_mode_q  <= 1'b0;
			main_count_q <= '0;
			bus_count_q  <= '0;
			io_count_q   <= '0;
			bus_rem_q    <= 1'b0;
			io_rem_q     <= '0;
			next_ident_q <= '0;
			earliest_q   <= '1;
			pend_vld_q   <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				hcount_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q     <= cmd;
						handler_q <= handler;
						delay_q   <= delay;
						payload_q <= payload;
						target_q  <= target_id;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					case (cmd_q)
						tesu_pkg::CMD_ADD: begin
							done_q <= 1'b1;
							if (bad_hndl) begin
								res_q <= make_res(tesu_pkg::ST_BAD_HNDL, '0, 1'b0, 1'b0,
									4'd0, 64'd0, 1'b1);
							end else if (full) begin
								res_q <= make_res(tesu_pkg::ST_FULL, '0, 1'b0, 1'b0,
									4'd0, 64'd0, 1'b1);
							end else begin
								res_q <= make_res(tesu_pkg::ST_OK, next_ident_q, 1'b0,
									1'b0, 4'd0, 64'd0, 1'b1);
								next_ident_q <= next_ident_q + 32'd1;
								n_q          <= n_q + CNT_W'(1);
								if (add_due < earliest_q) begin
									earliest_q <= add_due;
								end
							end
						end
						tesu_pkg::CMD_DEL: begin
							rd_q        <= '0;
							wr_q        <= '0;
							hit_q       <= 1'b0;
							fire_mode_q <= 1'b0;
							state_q     <= S_SCAN;
						end
						tesu_pkg::CMD_ADV: begin
							if (n_q == '0) begin
								done_q <= 1'b1;
								res_q  <= make_res(tesu_pkg::ST_EMPTY, '0, 1'b0, 1'b0,
									4'd0, 64'd0, 1'b1);
							end else begin
								run_q   <= run_d;
								state_q <= S_ADV2;
							end
						end
						default: begin
							done_q <= 1'b1;
							res_q  <= make_res(tesu_pkg::ST_OK, '0, 1'b0, 1'b0,
								4'd0, 64'd0, 1'b1);
						end
					endcase
				end
				S_ADV2: begin
					main_count_q <= main_count_q + 63'(run_q);
					bus_count_q  <= bus_count_q + 63'(half) + 63'(bcar);
					bus_rem_q    <= bus_rem_q ^ run_q[0];
					io_count_q   <= io_count_q + 63'(eighth) + 63'(io_sum[3]);
					io_rem_q     <= io_sum[2:0];
					brun_q       <= half + RUN_W'(bcar);
					irun_q       <= eighth + RUN_W'(io_sum[3]);
					state_q      <= S_ADV3;
				end
				S_ADV3: begin
					if (main_count_q >= earliest_q) begin
						rd_q        <= '0;
						wr_q        <= '0;
						fire_mode_q <= 1'b1;
						fresh_q     <= tesu_pkg::IDLE_TIME;
						pend_vld_q  <= 1'b0;
						state_q     <= S_SCAN;
					end else begin
						done_q  <= 1'b1;
						res_q   <= make_res(tesu_pkg::ST_OK, '0, 1'b1, 1'b0,
							4'd0, 64'd0, 1'b1);
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					vld_s1 <= issue;
					idx_s1 <= rd_q;
					if (issue) begin
						rd_q <= rd_q + CNT_W'(1);
					end
					if (vld_s1) begin
						if (drop) begin
							if (fire_mode_q) begin
								pend_vld_q     <= 1'b1;
								pend_handler_q <= rentry.handler;
								pend_payload_q <= rentry.payload;
								if (pend_vld_q) begin
									done_q <= 1'b1;
									res_q  <= make_res(tesu_pkg::ST_OK, '0, 1'b1, 1'b1,
										pend_handler_q, pend_payload_q, 1'b0);
								end
							end else begin
								hit_q <= 1'b1;
							end
						end else begin
							wr_q <= wr_q + CNT_W'(1);
							if (fire_mode_q && (rentry.due < fresh_q)) begin
								fresh_q <= rentry.due;
							end
						end
					end
					if (scan_end) begin
						n_q     <= wr_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (fire_mode_q) begin
							earliest_q <= fresh_q;
							res_q      <= make_res(tesu_pkg::ST_OK, '0, 1'b1, pend_vld_q,
								pend_vld_q ? pend_handler_q : 4'd0,
								pend_vld_q ? pend_payload_q : 64'd0, 1'b1);
						end else begin
							res_q <= make_res(hit_q ? tesu_pkg::ST_OK : tesu_pkg::ST_NOT_FOUND,
								'0, 1'b0, 1'b0, 4'd0, 64'd0, 1'b1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = res_q.status;
	assign new_id        = res_q.new_id;
	assign run_len       = res_q.run_len;
	assign bus_run_len   = res_q.bus_run_len;
	assign io_run_len    = res_q.io_run_len;
	assign fired         = res_q.fired;
	assign fired_handler = res_q.fired_handler;
	assign fired_payload = res_q.fired_payload;
	assign last          = res_q.last;

`include "timed_event_scheduler_unit_assert.svh"

	`TESU_ASSERT_NOW(a_count_bound, 1'b1, n_q <= CNT_W'(SLOTS), "event count above table size")
	`TESU_ASSERT_NOW(a_compact_order, state_q == S_SCAN, wr_q <= rd_q, "write pointer passed read pointer")
	`TESU_ASSERT_NOW(a_last_frees, done && last, !busy, "final result shown while still busy")
	`TESU_ASSERT_NEXT(a_take_request, start && !busy, busy, "request taken without going busy")

endmodule
`default_nettype wire

/* design/tesu_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module tesu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
